>>> sv/imu_dead_reckoning_integrator_unit_assert.svh
// ----------------------------------------------------------------------------
// IMU dead reckoning assertion macros
// Concurrent checks on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef IMU_DEAD_RECKONING_INTEGRATOR_UNIT_ASSERT_SVH
`define IMU_DEAD_RECKONING_INTEGRATOR_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// Antecedent implies consequent in the same cycle.
`define IMUDR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Antecedent implies consequent in the next cycle.
`define IMUDR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define IMUDR_ASSERT_SAME(lbl, ante, cons, msg)
`define IMUDR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> sv/imudr_pkg.sv
// ----------------------------------------------------------------------------
// imudr_pkg
// Constants, state encoding, sine quarter-wave table and helpers for the
// planar dead reckoning unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package imudr_pkg;

  // Table geometry; depth must be a power of two
  localparam int TRIG_TABLE_DEPTH = 1024;
  localparam int TRIG_WIDTH       = 16;
  localparam int IDX_W            = $clog2(TRIG_TABLE_DEPTH);
  localparam int QTR              = TRIG_TABLE_DEPTH / 4;
  localparam int QIDX_W           = IDX_W - 1;
  localparam int MAG_W            = TRIG_WIDTH - 1;

  // Field widths
  localparam int STAMP_W = 32;
  localparam int ACC_W   = 16;
  localparam int HEAD_W  = 17;
  localparam int POS_W   = 48;
  localparam int VEL_W   = 32;
  localparam int HM_W    = 16;

  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 216;

  // Sample kinds carried in tuser
  localparam logic OP_ACCEL   = 1'b0;
  localparam logic OP_HEADING = 1'b1;

  // Serial multiplier: magnitude A x magnitude B
  localparam int MA_W    = 33;
  localparam int MB_W    = 32;
  localparam int MP_W    = MA_W + MB_W;
  localparam int MCNT_W  = $clog2(MB_W + 1);

  // Serial divider: dividend magnitude / divisor
  localparam int DN_W    = MP_W + 1;
  localparam int DD_W    = 32;
  localparam int DCNT_W  = $clog2(DN_W + 1);
  localparam int QS_W    = DN_W + 1;

  localparam int DOT_W   = ACC_W + TRIG_WIDTH;
  localparam int G_W     = DOT_W + 1 + 6;
  localparam int SAT_IN_W = 41;

  localparam logic [HM_W:0]  FULL_TURN = 17'd46080;
  localparam logic [HM_W-1:0] HALF_TURN = 16'd23040;
  localparam logic [DD_W-1:0] USEC_PER_SEC = 32'd1000000;
  localparam logic [DD_W-1:0] HALF_USEC    = 32'd500000;
  localparam logic [DD_W-1:0] TWO_SEC_US   = 32'd2000000;
  localparam longint unsigned HALF_PI_Q30  = 64'd1686629713;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_IDX_LD,  ST_IDX_RUN,  ST_TRIG,
    ST_DOT1_LD, ST_DOT1_RUN, ST_DOT2_LD, ST_DOT2_RUN,
    ST_VMUL_LD, ST_VMUL_RUN, ST_VDIV_LD, ST_VDIV_RUN, ST_VEL,
    ST_PMUL_LD, ST_PMUL_RUN, ST_PDIV_LD, ST_PDIV_RUN, ST_POS,
    ST_YMUL_LD, ST_YMUL_RUN, ST_YDIV_LD, ST_YDIV_RUN, ST_YAW,
    ST_OUT
  } imudr_state_t;

  typedef logic [MAG_W-1:0] trig_mag_t;
  typedef trig_mag_t qsin_tbl_t [QTR+1];

  // Quarter-wave sine magnitudes, Q30 Taylor series, rounded half up
  function automatic qsin_tbl_t build_qsin_tbl();
    qsin_tbl_t tbl;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned mag;
    longint unsigned lim;
    longint acc;
    lim = (64'd1 << (TRIG_WIDTH - 1)) - 64'd1;
    for (int m = 0; m <= QTR; m++) begin
      x = 64'(16 * m) * HALF_PI_Q30 / (4 * TRIG_TABLE_DEPTH);
      x2 = (x * x) >> 30;
      term = x;
      acc = longint'(x);
      for (int k = 1; k <= 10; k++) begin
        term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
        if ((k % 2) == 1) acc = acc - longint'(term);
        else acc = acc + longint'(term);
      end
      if (acc < 0) acc = 0;
      if (acc > (64'sd1 <<< 30)) acc = 64'sd1 <<< 30;
      mag = ((64'(acc) << (TRIG_WIDTH - 1)) + (64'd1 << 29)) >> 30;
      if (mag > lim) mag = lim;
      tbl[m] = mag[MAG_W-1:0];
    end
    return tbl;
  endfunction

  localparam qsin_tbl_t QSIN_TBL = build_qsin_tbl();

  // sin(2*pi*k/depth) scaled by 2^(TRIG_WIDTH-1), by quadrant symmetry
  function automatic logic signed [TRIG_WIDTH-1:0] trig_val(input logic [IDX_W-1:0] k);
    logic [1:0]        quad;
    logic [QIDX_W-1:0] m;
    logic [QIDX_W-1:0] j;
    logic [TRIG_WIDTH-1:0] mag;
    quad = k[IDX_W-1 -: 2];
    m    = {1'b0, k[IDX_W-3:0]};
    j    = quad[0] ? (QIDX_W'(QTR) - m) : m;
    mag  = {1'b0, QSIN_TBL[j]};
    return quad[1] ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic signed [VEL_W-1:0] sat32(input logic signed [SAT_IN_W-1:0] v);
    if ((&v[SAT_IN_W-1:VEL_W-1]) || !(|v[SAT_IN_W-1:VEL_W-1])) return v[VEL_W-1:0];
    return v[SAT_IN_W-1] ? {1'b1, {(VEL_W-1){1'b0}}} : {1'b0, {(VEL_W-1){1'b1}}};
  endfunction

endpackage

`default_nettype wire

>>> sv/imu_dead_reckoning_integrator_unit.sv
// ----------------------------------------------------------------------------
// imu_dead_reckoning_integrator_unit
// Planar dead reckoning: heading samples give yaw rate, acceleration samples
// are rotated to the ground frame and integrated into velocity and position.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  tuser: opcode; tdata: stamp, accel, heading
//  m_*       out  m_tvalid/m_tready  tdata: pose (pos, vel, yaw rate, heading)
//
//  One sample is worked at a time; s_tready is high only while idle.
//  Both sample kinds are worked by the bit-serial divider and the bit-serial
//  multiplier; a heading sample with a zero interval skips both and sets the
//  yaw rate to zero.
//  rst (synchronous) clears the pose, stamps and heading to zero.
//  A finished pose waits in the output register; the next sample is taken
//  meanwhile, and a second finished pose holds until m_tready frees it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "imu_dead_reckoning_integrator_unit_assert.svh"

module imu_dead_reckoning_integrator_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // stamp_us[31:0], accel_x[47:32], accel_y[63:48], heading_in[80:64], zero pad
  input  logic [imudr_pkg::IN_TDATA_W-1:0]      s_tdata,
  // opcode: 0 acceleration sample, 1 heading sample
  input  logic [0:0]                            s_tuser,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // pos_x[47:0], pos_y[95:48], vel_x[127:96], vel_y[159:128],
  // yaw_rate[191:160], heading_out[208:192], zero pad
  output logic [imudr_pkg::OUT_TDATA_W-1:0]     m_tdata
);

  imudr_pkg::imudr_state_t state, state_next;

  // latched sample
  logic [imudr_pkg::STAMP_W-1:0]            stamp_r;
  logic signed [imudr_pkg::ACC_W-1:0]       ax_r, ay_r;
  logic signed [imudr_pkg::HEAD_W-1:0]      hin_r;

  // architectural state
  logic [imudr_pkg::STAMP_W-1:0]            last_accel_stamp, last_heading_stamp;
  logic signed [imudr_pkg::HEAD_W-1:0]      heading;
  logic signed [imudr_pkg::VEL_W-1:0]       yaw_rate_reg;
  logic signed [imudr_pkg::VEL_W-1:0]       velocity_x, velocity_y;
  logic [imudr_pkg::POS_W-1:0]              position_x, position_y;

  // working registers
  logic                                     axis;
  logic signed [imudr_pkg::TRIG_WIDTH-1:0]  cos_v, sin_v;
  logic signed [imudr_pkg::DOT_W-1:0]       dot;
  logic signed [imudr_pkg::VEL_W-1:0]       vnew;
  logic signed [imudr_pkg::VEL_W:0]         vsum;

  // serial multiplier
  logic [imudr_pkg::MP_W-1:0]               mul_a, mul_acc;
  logic [imudr_pkg::MB_W-1:0]               mul_b;
  logic                                     mul_neg;
  logic [imudr_pkg::MCNT_W-1:0]             mul_cnt;
  logic                                     mul_load;
  logic [imudr_pkg::MA_W-1:0]               ld_a;
  logic [imudr_pkg::MB_W-1:0]               ld_b;
  logic                                     ld_mneg;
  logic signed [imudr_pkg::MP_W:0]          prod_s;

  // serial divider
  logic [imudr_pkg::DN_W-1:0]               div_num;
  logic [imudr_pkg::DD_W-1:0]               div_rem, div_den;
  logic                                     div_neg, div_floor;
  logic [imudr_pkg::DCNT_W-1:0]             div_cnt;
  logic                                     div_load;
  logic signed [imudr_pkg::QS_W-1:0]        ld_n, ld_nmag;
  logic [imudr_pkg::DD_W-1:0]               ld_den;
  logic                                     ld_floor;
  logic [imudr_pkg::DD_W:0]                 div_trial;
  logic                                     div_ge;
  logic [imudr_pkg::QS_W-1:0]               qmag;
  logic signed [imudr_pkg::QS_W-1:0]        quo_s;

  // datapath helpers
  logic [imudr_pkg::STAMP_W-1:0]            dt_acc, dt_head;
  logic signed [imudr_pkg::HEAD_W+1:0]      hwide;
  logic [imudr_pkg::HM_W-1:0]               hm;
  logic signed [imudr_pkg::HEAD_W:0]        diff;
  logic [imudr_pkg::HEAD_W:0]               diff_mag;
  logic signed [imudr_pkg::ACC_W-1:0]       acc_op;
  logic signed [imudr_pkg::TRIG_WIDTH-1:0]  trig_op;
  logic                                     flip;
  logic [imudr_pkg::ACC_W-1:0]              acc_mag;
  logic [imudr_pkg::TRIG_WIDTH-1:0]         trig_mag;
  logic signed [imudr_pkg::DOT_W:0]         gsum;
  logic signed [imudr_pkg::G_W-1:0]         g_wide, g_val;
  logic [imudr_pkg::G_W-1:0]                g_mag;
  logic [imudr_pkg::VEL_W:0]                vsum_mag;
  logic [imudr_pkg::IDX_W:0]                idx_q;
  logic [imudr_pkg::IDX_W-1:0]              idx;
  logic signed [imudr_pkg::VEL_W-1:0]       v_old;
  logic signed [imudr_pkg::SAT_IN_W-1:0]    vel_sum;
  logic signed [imudr_pkg::VEL_W-1:0]       vnew_c;

  assign dt_acc  = stamp_r - last_accel_stamp;
  assign dt_head = stamp_r - last_heading_stamp;

  // heading reduced into [0, full turn) for the table index
  always_comb begin
    hwide = {{2{heading[imudr_pkg::HEAD_W-1]}}, heading};
    if (hwide < -$signed({2'b00, imudr_pkg::FULL_TURN})) begin
      hwide = hwide + $signed({1'b0, imudr_pkg::FULL_TURN, 1'b0});
    end else if (hwide < 0) begin
      hwide = hwide + $signed({2'b00, imudr_pkg::FULL_TURN});
    end else if (hwide >= $signed({2'b00, imudr_pkg::FULL_TURN})) begin
      hwide = hwide - $signed({2'b00, imudr_pkg::FULL_TURN});
    end
    hm = hwide[imudr_pkg::HM_W-1:0];
  end

  assign diff     = {hin_r[imudr_pkg::HEAD_W-1], hin_r} - {heading[imudr_pkg::HEAD_W-1], heading};
  assign diff_mag = diff[imudr_pkg::HEAD_W] ? -diff : diff;

  // signed product and quotient as seen by the sequencer
  assign prod_s = mul_neg ? -$signed({1'b0, mul_acc}) : $signed({1'b0, mul_acc});
  assign qmag   = {1'b0, div_num};
  assign quo_s  = div_neg
                ? -$signed(qmag + imudr_pkg::QS_W'(div_floor && (div_rem != '0)))
                : $signed(qmag);

  // ground acceleration: rounded (dot * 64) / 2^(TRIG_WIDTH-1)
  assign gsum   = {dot[imudr_pkg::DOT_W-1], dot} + prod_s[imudr_pkg::DOT_W:0];
  assign g_wide = $signed({gsum, 6'b0})
                + $signed(imudr_pkg::G_W'(1) << (imudr_pkg::TRIG_WIDTH - 2));
  assign g_val  = g_wide >>> (imudr_pkg::TRIG_WIDTH - 1);
  assign g_mag  = g_val[imudr_pkg::G_W-1] ? -g_val : g_val;

  assign vsum_mag = vsum[imudr_pkg::VEL_W] ? -vsum : vsum;

  assign idx_q = div_num[imudr_pkg::IDX_W:0];
  assign idx   = (idx_q == (imudr_pkg::IDX_W+1)'(imudr_pkg::TRIG_TABLE_DEPTH))
               ? '0 : idx_q[imudr_pkg::IDX_W-1:0];

  assign v_old   = axis ? velocity_y : velocity_x;
  assign vel_sum = {{(imudr_pkg::SAT_IN_W-imudr_pkg::VEL_W){v_old[imudr_pkg::VEL_W-1]}}, v_old}
                 + quo_s[imudr_pkg::SAT_IN_W-1:0];
  assign vnew_c  = imudr_pkg::sat32(vel_sum);

  // rotation operands: x = ax*cos - ay*sin, y = ax*sin + ay*cos
  always_comb begin
    acc_op  = ax_r;
    trig_op = axis ? sin_v : cos_v;
    flip    = 1'b0;
    if (state == imudr_pkg::ST_DOT2_LD) begin
      acc_op  = ay_r;
      trig_op = axis ? cos_v : sin_v;
      flip    = !axis;
    end
  end
  assign acc_mag  = acc_op[imudr_pkg::ACC_W-1] ? -acc_op : acc_op;
  assign trig_mag = trig_op[imudr_pkg::TRIG_WIDTH-1] ? -trig_op : trig_op;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      imudr_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = (s_tuser[0] == imudr_pkg::OP_HEADING) ? imudr_pkg::ST_YMUL_LD
                                                              : imudr_pkg::ST_IDX_LD;
        end
      end
      imudr_pkg::ST_IDX_LD:   state_next = imudr_pkg::ST_IDX_RUN;
      imudr_pkg::ST_IDX_RUN:  if (div_cnt == '0) state_next = imudr_pkg::ST_TRIG;
      imudr_pkg::ST_TRIG:     state_next = imudr_pkg::ST_DOT1_LD;
      imudr_pkg::ST_DOT1_LD:  state_next = imudr_pkg::ST_DOT1_RUN;
      imudr_pkg::ST_DOT1_RUN: if (mul_cnt == '0) state_next = imudr_pkg::ST_DOT2_LD;
      imudr_pkg::ST_DOT2_LD:  state_next = imudr_pkg::ST_DOT2_RUN;
      imudr_pkg::ST_DOT2_RUN: if (mul_cnt == '0) state_next = imudr_pkg::ST_VMUL_LD;
      imudr_pkg::ST_VMUL_LD:  state_next = imudr_pkg::ST_VMUL_RUN;
      imudr_pkg::ST_VMUL_RUN: if (mul_cnt == '0) state_next = imudr_pkg::ST_VDIV_LD;
      imudr_pkg::ST_VDIV_LD:  state_next = imudr_pkg::ST_VDIV_RUN;
      imudr_pkg::ST_VDIV_RUN: if (div_cnt == '0) state_next = imudr_pkg::ST_VEL;
      imudr_pkg::ST_VEL:      state_next = imudr_pkg::ST_PMUL_LD;
      imudr_pkg::ST_PMUL_LD:  state_next = imudr_pkg::ST_PMUL_RUN;
      imudr_pkg::ST_PMUL_RUN: if (mul_cnt == '0) state_next = imudr_pkg::ST_PDIV_LD;
      imudr_pkg::ST_PDIV_LD:  state_next = imudr_pkg::ST_PDIV_RUN;
      imudr_pkg::ST_PDIV_RUN: if (div_cnt == '0) state_next = imudr_pkg::ST_POS;
      imudr_pkg::ST_POS:      state_next = axis ? imudr_pkg::ST_OUT : imudr_pkg::ST_DOT1_LD;
      imudr_pkg::ST_YMUL_LD: begin
        state_next = (dt_head == '0) ? imudr_pkg::ST_YAW : imudr_pkg::ST_YMUL_RUN;
      end
      imudr_pkg::ST_YMUL_RUN: if (mul_cnt == '0) state_next = imudr_pkg::ST_YDIV_LD;
      imudr_pkg::ST_YDIV_LD:  state_next = imudr_pkg::ST_YDIV_RUN;
      imudr_pkg::ST_YDIV_RUN: if (div_cnt == '0) state_next = imudr_pkg::ST_YAW;
      imudr_pkg::ST_YAW:      state_next = imudr_pkg::ST_OUT;
      imudr_pkg::ST_OUT:      if (!m_tvalid || m_tready) state_next = imudr_pkg::ST_IDLE;
      default:                state_next = imudr_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs: handshake and engine operands
  always_comb begin
    s_tready = 1'b0;
    mul_load = 1'b0;
    ld_a     = '0;
    ld_b     = '0;
    ld_mneg  = 1'b0;
    div_load = 1'b0;
    ld_n     = '0;
    ld_den   = imudr_pkg::USEC_PER_SEC;
    ld_floor = 1'b1;
    case (state)
      imudr_pkg::ST_IDLE: s_tready = 1'b1;
      imudr_pkg::ST_IDX_LD: begin
        div_load = 1'b1;
        ld_n     = $signed(imudr_pkg::QS_W'({hm, imudr_pkg::IDX_W'(0)})
                 + imudr_pkg::QS_W'(imudr_pkg::HALF_TURN));
        ld_den   = imudr_pkg::DD_W'(imudr_pkg::FULL_TURN);
      end
      imudr_pkg::ST_DOT1_LD, imudr_pkg::ST_DOT2_LD: begin
        mul_load = 1'b1;
        ld_a     = imudr_pkg::MA_W'(acc_mag);
        ld_b     = imudr_pkg::MB_W'(trig_mag);
        ld_mneg  = acc_op[imudr_pkg::ACC_W-1] ^ trig_op[imudr_pkg::TRIG_WIDTH-1] ^ flip;
      end
      imudr_pkg::ST_VMUL_LD: begin
        mul_load = 1'b1;
        ld_a     = imudr_pkg::MA_W'(g_mag);
        ld_b     = dt_acc;
        ld_mneg  = g_val[imudr_pkg::G_W-1];
      end
      imudr_pkg::ST_VDIV_LD: begin
        div_load = 1'b1;
        ld_n     = {prod_s[imudr_pkg::MP_W], prod_s}
                 + $signed(imudr_pkg::QS_W'(imudr_pkg::HALF_USEC));
      end
      imudr_pkg::ST_PMUL_LD: begin
        mul_load = 1'b1;
        ld_a     = imudr_pkg::MA_W'(vsum_mag);
        ld_b     = dt_acc;
        ld_mneg  = vsum[imudr_pkg::VEL_W];
      end
      imudr_pkg::ST_PDIV_LD: begin
        div_load = 1'b1;
        ld_n     = {prod_s[imudr_pkg::MP_W], prod_s}
                 + $signed(imudr_pkg::QS_W'(imudr_pkg::USEC_PER_SEC));
        ld_den   = imudr_pkg::TWO_SEC_US;
      end
      imudr_pkg::ST_YMUL_LD: begin
        // skip the multiply when the interval is zero
        mul_load = (dt_head != '0);
        ld_a     = imudr_pkg::MA_W'(diff_mag);
        ld_b     = imudr_pkg::USEC_PER_SEC;
        ld_mneg  = diff[imudr_pkg::HEAD_W];
      end
      imudr_pkg::ST_YDIV_LD: begin
        div_load = 1'b1;
        ld_n     = {prod_s[imudr_pkg::MP_W], prod_s};
        ld_den   = dt_head;
        ld_floor = 1'b0;
      end
      default: ;
    endcase
  end

  assign ld_nmag   = ld_n[imudr_pkg::QS_W-1] ? -ld_n : ld_n;
  assign div_trial = {div_rem, div_num[imudr_pkg::DN_W-1]};
  assign div_ge    = div_trial >= {1'b0, div_den};

  // shift-and-add multiplier, one multiplier bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_cnt <= '0;
    end else if (mul_load) begin
      mul_a   <= imudr_pkg::MP_W'(ld_a);
      mul_b   <= ld_b;
      mul_acc <= '0;
      mul_neg <= ld_mneg;
      mul_cnt <= imudr_pkg::MCNT_W'(imudr_pkg::MB_W);
    end else if (mul_cnt != '0) begin
      if (mul_b[0]) mul_acc <= mul_acc + mul_a;
      mul_a   <= {mul_a[imudr_pkg::MP_W-2:0], 1'b0};
      mul_b   <= {1'b0, mul_b[imudr_pkg::MB_W-1:1]};
      mul_cnt <= mul_cnt - 1'b1;
    end
  end

  // restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (div_load) begin
      div_num   <= ld_nmag[imudr_pkg::DN_W-1:0];
      div_rem   <= '0;
      div_den   <= ld_den;
      div_neg   <= ld_n[imudr_pkg::QS_W-1];
      div_floor <= ld_floor;
      div_cnt   <= imudr_pkg::DCNT_W'(imudr_pkg::DN_W);
    end else if (div_cnt != '0) begin
      div_rem <= div_ge ? imudr_pkg::DD_W'(div_trial - {1'b0, div_den})
                        : div_trial[imudr_pkg::DD_W-1:0];
      div_num <= {div_num[imudr_pkg::DN_W-2:0], div_ge};
      div_cnt <= div_cnt - 1'b1;
    end
  end

  // sample latch and working registers
  always_ff @(posedge clk) begin
    if (state == imudr_pkg::ST_IDLE && s_tvalid) begin
      stamp_r <= s_tdata[31:0];
      ax_r    <= s_tdata[47:32];
      ay_r    <= s_tdata[63:48];
      hin_r   <= s_tdata[80:64];
    end
    if (state == imudr_pkg::ST_TRIG) begin
      sin_v <= imudr_pkg::trig_val(idx);
      cos_v <= imudr_pkg::trig_val(idx + imudr_pkg::IDX_W'(imudr_pkg::QTR));
    end
    if (state == imudr_pkg::ST_DOT2_LD) dot <= prod_s[imudr_pkg::DOT_W-1:0];
    if (state == imudr_pkg::ST_VEL) begin
      vnew <= vnew_c;
      vsum <= {v_old[imudr_pkg::VEL_W-1], v_old} + {vnew_c[imudr_pkg::VEL_W-1], vnew_c};
    end
  end

  // sequencer state, axis and pose
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= imudr_pkg::ST_IDLE;
      axis               <= 1'b0;
      last_accel_stamp   <= '0;
      last_heading_stamp <= '0;
      heading            <= '0;
      yaw_rate_reg       <= '0;
      velocity_x         <= '0;
      velocity_y         <= '0;
      position_x         <= '0;
      position_y         <= '0;
    end else begin
      state <= state_next;
      if (state == imudr_pkg::ST_IDLE) axis <= 1'b0;
      if (state == imudr_pkg::ST_POS) begin
        // advance this axis, then move to the other one or finish
        if (axis) begin
          velocity_y       <= vnew;
          position_y       <= position_y + quo_s[imudr_pkg::POS_W-1:0];
          last_accel_stamp <= stamp_r;
        end else begin
          velocity_x <= vnew;
          position_x <= position_x + quo_s[imudr_pkg::POS_W-1:0];
        end
        axis <= 1'b1;
      end
      if (state == imudr_pkg::ST_YAW) begin
        yaw_rate_reg       <= (dt_head == '0) ? '0
                            : imudr_pkg::sat32(quo_s[imudr_pkg::SAT_IN_W-1:0]);
        heading            <= hin_r;
        last_heading_stamp <= stamp_r;
      end
    end
  end

  // output register: hold the pose until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == imudr_pkg::ST_OUT && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == imudr_pkg::ST_OUT && (!m_tvalid || m_tready)) begin
      m_tdata <= {7'b0, heading, yaw_rate_reg, velocity_y, velocity_x, position_y, position_x};
    end
  end

  // engines only step in their wait states
  `IMUDR_ASSERT_SAME(a_mul_owner, mul_cnt != '0,
    (state == imudr_pkg::ST_DOT1_RUN) || (state == imudr_pkg::ST_DOT2_RUN) ||
    (state == imudr_pkg::ST_VMUL_RUN) || (state == imudr_pkg::ST_PMUL_RUN) ||
    (state == imudr_pkg::ST_YMUL_RUN), "multiplier running outside its wait state")
  `IMUDR_ASSERT_SAME(a_div_owner, div_cnt != '0,
    (state == imudr_pkg::ST_IDX_RUN) || (state == imudr_pkg::ST_VDIV_RUN) ||
    (state == imudr_pkg::ST_PDIV_RUN) || (state == imudr_pkg::ST_YDIV_RUN),
    "divider running outside its wait state")
  // partial remainder stays below the divisor
  `IMUDR_ASSERT_SAME(a_div_rem, div_cnt != '0, div_rem < div_den,
    "divider remainder not below divisor")
  // heading path never touches the second axis
  `IMUDR_ASSERT_SAME(a_head_axis, state == imudr_pkg::ST_YAW, !axis,
    "axis select set on heading path")
  // a finished pose is presented the next cycle
  `IMUDR_ASSERT_NEXT(a_out_load, state == imudr_pkg::ST_OUT && (!m_tvalid || m_tready),
    m_tvalid && state == imudr_pkg::ST_IDLE, "pose not presented after finish")

endmodule

`default_nettype wire
